// ===== hw/rtl/tfw_pkg.sv =====
// Shared types and constants for the thermostat with fault watch.
// No dependencies; every other file in hw/rtl imports this package.
package tfw_pkg;

  localparam int unsigned LIMIT_W   = 7;
  localparam int unsigned TEMP_W    = 16;
  localparam int unsigned CNT_W     = 10;
  localparam int unsigned BAND_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CENTI     = 100;
  localparam int unsigned LIMIT_MAX = (1 << LIMIT_W) - 1;
  localparam int unsigned QDEPTH    = 2;

  localparam int unsigned PASSES_PER_UNIT_DEF = 10;

  localparam logic [LIMIT_W-1:0] HIGH_RST = 7'd40;
  localparam logic [LIMIT_W-1:0] LOW_RST  = 7'd20;
  localparam logic [LIMIT_W-1:0] PASS_RST = 7'd45;
  localparam logic [LIMIT_W-1:0] HALF_RST = 7'd10;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIGH_LIMIT = 2'd0,
    REG_LOW_LIMIT  = 2'd1,
    REG_PASS_LIMIT = 2'd2
  } reg_idx_e;

  typedef enum logic [BAND_W-1:0] {
    BAND_WITHIN = 2'd0,
    BAND_HIGH   = 2'd1,
    BAND_LOW    = 2'd2,
    BAND_NONE   = 2'd3
  } band_e;

  typedef struct packed {
    logic              action;
    logic [TEMP_W-1:0] temp_centi;
  } req_t;

  typedef struct packed {
    logic              heater_drive;
    logic              cooler_drive;
    logic              heater_alarm;
    logic              cooler_alarm;
    logic [BAND_W-1:0] band;
  } rsp_t;

  // Classified request as it travels from the front to the back.
  typedef struct packed {
    logic action;
    logic hit_high;
    logic hit_low;
    logic in_zone;
  } cls_t;

  typedef struct packed {
    logic                          empty;
    logic                          full;
    logic [$clog2(QDEPTH+1)-1:0]   count;
  } q_status_t;

endpackage

// ===== hw/rtl/tfw_front.sv =====
// Front part: limit registers, half-band and fault target, and request classification.
// Depends on tfw_pkg.
module tfw_front #(
  parameter int unsigned PassesPerUnit = tfw_pkg::PASSES_PER_UNIT_DEF,
  parameter int unsigned TgtW          = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tfw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tfw_pkg::LIMIT_W-1:0]  cfg_wdata_i,
  input  tfw_pkg::req_t                req_i,
  output tfw_pkg::cls_t                cls_o,
  output logic [TgtW-1:0]              target_o
);
  import tfw_pkg::*;

  localparam int unsigned CmpW = TEMP_W + 1;

  logic [LIMIT_W-1:0] high_q, high_d;
  logic [LIMIT_W-1:0] low_q, low_d;
  logic [LIMIT_W-1:0] half_q, half_d;
  logic [TgtW-1:0]    target_q, target_d;

  always_comb begin
    high_d   = high_q;
    low_d    = low_q;
    target_d = target_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_HIGH_LIMIT: high_d = cfg_wdata_i;
        REG_LOW_LIMIT:  low_d  = cfg_wdata_i;
        REG_PASS_LIMIT: target_d = TgtW'(int'(cfg_wdata_i) * PassesPerUnit);
        default: ;
      endcase
    end
    // A reversed band gives no hysteresis zone at all.
    if (high_d >= low_d) begin
      half_d = (high_d - low_d) >> 1;
    end else begin
      half_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_q   <= HIGH_RST;
      low_q    <= LOW_RST;
      half_q   <= HALF_RST;
      target_q <= TgtW'(int'(PASS_RST) * PassesPerUnit);
    end else begin
      high_q   <= high_d;
      low_q    <= low_d;
      half_q   <= half_d;
      target_q <= target_d;
    end
  end

  logic [CmpW-1:0] temp_c, hi_c, lo_c, hi_zone_c, lo_zone_c;
  logic [LIMIT_W:0] lo_zone_deg;

  always_comb begin
    lo_zone_deg = {1'b0, low_q} + {1'b0, half_q};
    temp_c      = CmpW'(req_i.temp_centi);
    hi_c        = CmpW'(high_q) * CmpW'(CENTI);
    lo_c        = CmpW'(low_q) * CmpW'(CENTI);
    hi_zone_c   = CmpW'(high_q - half_q) * CmpW'(CENTI);
    lo_zone_c   = CmpW'(lo_zone_deg) * CmpW'(CENTI);

    cls_o.action   = req_i.action;
    cls_o.hit_high = temp_c >= hi_c;
    cls_o.hit_low  = temp_c <= lo_c;
    cls_o.in_zone  = (temp_c < hi_c && temp_c >= hi_zone_c) ||
                     (temp_c > lo_c && temp_c < lo_zone_c);
  end

  assign target_o = target_q;

endmodule

// ===== hw/rtl/tfw_queue.sv =====
// Two-entry queue of classified requests between the front and the back.
// Depends on tfw_pkg.
module tfw_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  tfw_pkg::cls_t        push_data_i,
  input  logic                 pop_i,
  output tfw_pkg::cls_t        pop_data_o,
  output tfw_pkg::q_status_t   status_o
);
  import tfw_pkg::*;

  localparam int unsigned PtrW = $clog2(QDEPTH);
  localparam int unsigned CntW = $clog2(QDEPTH + 1);

  cls_t            mem_q [QDEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o     = mem_q[rd_ptr_q];
  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CntW'(QDEPTH));
  assign status_o.count = count_q;

endmodule

// ===== hw/rtl/tfw_back.sv =====
// Back part: drive and fault state, the out-of-band counter and the result register.
// Depends on tfw_pkg.
module tfw_back #(
  parameter int unsigned TgtW = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  tfw_pkg::cls_t     cls_i,
  input  logic [TgtW-1:0]   target_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output tfw_pkg::rsp_t     out_data_o,
  output logic              room_o
);
  import tfw_pkg::*;

  localparam int unsigned CmpW = (TgtW > CNT_W) ? TgtW : CNT_W;

  logic             heater_q, heater_d;
  logic             cooler_q, cooler_d;
  logic             hfault_q, hfault_d;
  logic             cfault_q, cfault_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_data_q, out_data_d;
  band_e            band;
  logic [CNT_W-1:0] bumped;

  assign room_o = !out_valid_q || out_ready_i;

  always_comb begin
    heater_d    = heater_q;
    cooler_d    = cooler_q;
    hfault_d    = hfault_q;
    cfault_d    = cfault_q;
    cnt_d       = cnt_q;
    band        = BAND_NONE;
    bumped      = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;

    if (load_i) begin
      if (cls_i.action) begin
        hfault_d = 1'b0;
        cfault_d = 1'b0;
      end else begin
        // The high side is handled first; a reversed band may hit both.
        if (cls_i.hit_high) begin
          band = BAND_HIGH;
          if (!cfault_d) begin
            heater_d = 1'b0;
            cooler_d = 1'b1;
            bumped   = (cnt_d < CNT_MAX) ? cnt_d + 1'b1 : cnt_d;
            cnt_d    = bumped;
            if (CmpW'(bumped) == CmpW'(target_i)) begin
              cfault_d = 1'b1;
              heater_d = 1'b0;
              cooler_d = 1'b0;
              cnt_d    = '0;
            end
          end
        end
        if (cls_i.hit_low) begin
          band = BAND_LOW;
          if (!hfault_d) begin
            heater_d = 1'b1;
            cooler_d = 1'b0;
            bumped   = (cnt_d < CNT_MAX) ? cnt_d + 1'b1 : cnt_d;
            cnt_d    = bumped;
            if (CmpW'(bumped) == CmpW'(target_i)) begin
              hfault_d = 1'b1;
              heater_d = 1'b0;
              cooler_d = 1'b0;
              cnt_d    = '0;
            end
          end
        end
        if (cls_i.in_zone) begin
          band     = BAND_WITHIN;
          heater_d = 1'b0;
          cooler_d = 1'b0;
        end
      end
      out_valid_d             = 1'b1;
      out_data_d.heater_drive = heater_d;
      out_data_d.cooler_drive = cooler_d;
      out_data_d.heater_alarm = hfault_d;
      out_data_d.cooler_alarm = cfault_d;
      out_data_d.band         = band;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heater_q    <= 1'b0;
      cooler_q    <= 1'b0;
      hfault_q    <= 1'b0;
      cfault_q    <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      heater_q    <= heater_d;
      cooler_q    <= cooler_d;
      hfault_q    <= hfault_d;
      cfault_q    <= cfault_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hw/rtl/thermostat_with_fault_watch.sv =====
// Thermostat with fault watch: top level joining front, request queue and back.
// Flow: an accepted request waits in the queue until the back's result register has room,
// that is until earlier results are taken on out_ready_i. Throughput: one request per cycle
// while out_ready_i is high; the back's state update sets the pace. Reset: rst_ni clears
// drives, faults, counter, queue and result valid, and loads high, low, half band and target
// with 40, 20, 10, 45*PassesPerUnit. Depends on tfw_pkg, tfw_front, tfw_queue, tfw_back.
module thermostat_with_fault_watch #(
  parameter int unsigned PassesPerUnit = tfw_pkg::PASSES_PER_UNIT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tfw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tfw_pkg::LIMIT_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tfw_pkg::req_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tfw_pkg::rsp_t                 out_data_o
);
  import tfw_pkg::*;

  localparam int unsigned TgtW = $clog2(LIMIT_MAX * PassesPerUnit + 1);

  cls_t            front_cls;
  cls_t            q_head;
  q_status_t       q_status;
  logic [TgtW-1:0] target;
  logic            push;
  logic            pop;
  logic            back_room;

  assign in_ready_o = !q_status.full;
  assign push       = in_valid_i && in_ready_o;
  assign pop        = !q_status.empty && back_room;

  tfw_front #(
    .PassesPerUnit(PassesPerUnit),
    .TgtW         (TgtW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (in_data_i),
    .cls_o      (front_cls),
    .target_o   (target)
  );

  tfw_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(front_cls),
    .pop_i      (pop),
    .pop_data_o (q_head),
    .status_o   (q_status)
  );

  tfw_back #(
    .TgtW(TgtW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (pop),
    .cls_i      (q_head),
    .target_i   (target),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .room_o     (back_room)
  );

  // Heater and cooler are never driven together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.heater_drive && out_data_o.cooler_drive))
    else $error("heater and cooler driven together");

  // A clear request always reports both alarms off and no band.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && q_head.action |=> !out_data_o.heater_alarm && !out_data_o.cooler_alarm &&
      out_data_o.band == BAND_NONE)
    else $error("clear request did not clear alarms");

  // An accepted request is held in the queue or already taken by the back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> q_status.count != '0 || $past(pop))
    else $error("accepted request lost from queue");

  // A newly latched fault turns its own drive off. The low side is handled last, so a
  // new heater fault leaves both off, while a reversed band may turn the heater on
  // right after a new cooler fault.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (!$rose(out_data_o.heater_alarm) ||
       (!out_data_o.heater_drive && !out_data_o.cooler_drive)) &&
      (!$rose(out_data_o.cooler_alarm) || !out_data_o.cooler_drive))
    else $error("fault latched with a drive on");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for thermostat_with_fault_watch: random-paced requests under
// several limit settings, each result checked against an in-bench thermostat model.
// Depends on tfw_pkg and the thermostat_with_fault_watch RTL.
module tb;
  import tfw_pkg::*;

  localparam int unsigned PASSES      = PASSES_PER_UNIT_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TAIL_OPS    = 150;
  localparam int unsigned SETTLE      = 3;
  localparam int unsigned MAX_PRINTS  = 50;
  localparam int unsigned TEMP_MAX    = (1 << TEMP_W) - 1;

  typedef struct {
    bit                 is_write;
    reg_idx_e           idx;
    logic [LIMIT_W-1:0] val;
    req_t               req;
  } thermo_op_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [LIMIT_W-1:0]   cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  req_t                 in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  rsp_t                 out_data_o;

  thermo_op_t pending_ops[$];
  rsp_t       predicted_rsp_q[$];

  // Model copy of the controller state and limit registers.
  logic [LIMIT_W-1:0] high_lim = HIGH_RST;
  logic [LIMIT_W-1:0] low_lim  = LOW_RST;
  logic [LIMIT_W-1:0] pass_lim = PASS_RST;
  int unsigned        half_bnd = HALF_RST;
  bit                 heat_on, cool_on, heat_flt, cool_flt;
  int unsigned        oob_cnt;

  int unsigned err_count, req_count, write_count;
  int unsigned heater_trips, cooler_trips, sat_ticks;
  int unsigned gap_left, stall_left, quiet_cycles, cycle_count;

  always #10 clk_i = ~clk_i;

  thermostat_with_fault_watch #(
    .PassesPerUnit(PASSES)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  function automatic int unsigned half_band_of(int unsigned hi, int unsigned lo);
    return (hi >= lo) ? (hi - lo) / 2 : 0;
  endfunction

  // Saturating counter bump; returns 1 when the fault target is reached.
  function automatic bit bump_hits_target();
    if (oob_cnt < CNT_MAX) oob_cnt++;
    else sat_ticks++;
    return oob_cnt == int'(pass_lim) * PASSES;
  endfunction

  function automatic rsp_t thermo_step(req_t r);
    rsp_t        res;
    band_e       b;
    int unsigned t, hi, lo, hz, lz;
    b = BAND_NONE;
    if (r.action) begin
      heat_flt = 1'b0;
      cool_flt = 1'b0;
    end else begin
      t  = r.temp_centi;
      hi = high_lim * CENTI;
      lo = low_lim * CENTI;
      hz = (high_lim - half_bnd) * CENTI;
      lz = (low_lim + half_bnd) * CENTI;
      // The high side is handled first, so a reversed band reports low.
      if (t >= hi) begin
        b = BAND_HIGH;
        if (!cool_flt) begin
          heat_on = 1'b0;
          cool_on = 1'b1;
          if (bump_hits_target()) begin
            cool_flt = 1'b1;
            cool_on  = 1'b0;
            oob_cnt  = 0;
            cooler_trips++;
          end
        end
      end
      if (t <= lo) begin
        b = BAND_LOW;
        if (!heat_flt) begin
          heat_on = 1'b1;
          cool_on = 1'b0;
          if (bump_hits_target()) begin
            heat_flt = 1'b1;
            heat_on  = 1'b0;
            oob_cnt  = 0;
            heater_trips++;
          end
        end
      end
      if ((t < hi && t >= hz) || (t > lo && t < lz)) begin
        b       = BAND_WITHIN;
        heat_on = 1'b0;
        cool_on = 1'b0;
      end
    end
    res.heater_drive = heat_on;
    res.cooler_drive = cool_on;
    res.heater_alarm = heat_flt;
    res.cooler_alarm = cool_flt;
    res.band         = b;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  function automatic logic [TEMP_W-1:0] clamp_temp(int v);
    if (v < 0) return '0;
    if (v > int'(TEMP_MAX)) return TEMP_W'(TEMP_MAX);
    return TEMP_W'(v);
  endfunction

  task automatic push_tick(bit act, int unsigned t);
    thermo_op_t op;
    op.is_write       = 1'b0;
    op.idx            = REG_HIGH_LIMIT;
    op.val            = '0;
    op.req.action     = act;
    op.req.temp_centi = TEMP_W'(t);
    pending_ops.push_back(op);
  endtask

  task automatic push_write(reg_idx_e idx, int unsigned v);
    thermo_op_t op;
    op.is_write = 1'b1;
    op.idx      = idx;
    op.val      = LIMIT_W'(v);
    op.req      = '0;
    pending_ops.push_back(op);
  endtask

  // One setting of the three registers followed by n random requests, most of
  // them aimed at the limits and zone edges of that setting.
  task automatic random_phase(int h, int l, int p, int n, int oob_pct);
    int hi, lo, hb, hz, lz, t, r;
    push_write(REG_HIGH_LIMIT, h);
    push_write(REG_LOW_LIMIT, l);
    push_write(REG_PASS_LIMIT, p);
    hi = h * CENTI;
    lo = l * CENTI;
    hb = half_band_of(h, l);
    hz = (h - hb) * CENTI;
    lz = (l + hb) * CENTI;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        push_tick(1'b1, $urandom_range(0, TEMP_MAX));
      end else begin
        if (r < oob_pct) begin
          if ($urandom_range(0, 1)) t = hi + int'($urandom_range(0, 2000));
          else t = $urandom_range(0, lo);
        end else begin
          case ($urandom_range(0, 5))
            0: t = $urandom_range(0, TEMP_MAX);
            1: t = $urandom_range(lo, hi);
            2: t = hz - 1 + int'($urandom_range(0, 2));
            3: t = lz - 2 + int'($urandom_range(0, 2));
            4: t = hi - 1;
            default: t = lo + 1 + int'($urandom_range(0, 1));
          endcase
        end
        push_tick(1'b0, clamp_temp(t));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    thermo_op_t         op;
    logic               valid_nxt, we_nxt;
    req_t               data_nxt;
    logic [CFG_IDX_W-1:0] idx_nxt;
    logic [LIMIT_W-1:0] wdata_nxt;
    bit                 took;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      in_data_i   <= '0;
      cfg_we_i    <= 1'b0;
      cfg_idx_i   <= '0;
      cfg_wdata_i <= '0;
    end else begin
      took      = in_valid_i && in_ready_o;
      valid_nxt = in_valid_i && !took;
      data_nxt  = in_data_i;
      we_nxt    = 1'b0;
      idx_nxt   = cfg_idx_i;
      wdata_nxt = cfg_wdata_i;
      if (took) begin
        predicted_rsp_q.push_back(thermo_step(in_data_i));
        req_count++;
      end
      if (predicted_rsp_q.size() == 0 && !in_valid_i) quiet_cycles++;
      else quiet_cycles = 0;
      if (!valid_nxt && pending_ops.size() != 0) begin
        if (pending_ops[0].is_write) begin
          // Registers change only once every result has drained.
          if (quiet_cycles >= SETTLE) begin
            op        = pending_ops.pop_front();
            we_nxt    = 1'b1;
            idx_nxt   = op.idx;
            wdata_nxt = op.val;
            write_count++;
            case (op.idx)
              REG_HIGH_LIMIT: high_lim = op.val;
              REG_LOW_LIMIT:  low_lim  = op.val;
              REG_PASS_LIMIT: pass_lim = op.val;
              default: ;
            endcase
            half_bnd = half_band_of(high_lim, low_lim);
          end
        end else if (gap_left != 0) begin
          gap_left--;
        end else if (pending_ops.size() > TAIL_OPS && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 13);
        end else begin
          op        = pending_ops.pop_front();
          valid_nxt = 1'b1;
          data_nxt  = op.req;
        end
      end
      in_valid_i  <= valid_nxt;
      in_data_i   <= data_nxt;
      cfg_we_i    <= we_nxt;
      cfg_idx_i   <= idx_nxt;
      cfg_wdata_i <= wdata_nxt;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : check_results
    rsp_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (predicted_rsp_q.size() == 0) begin
          report_mismatch($sformatf("result %p with no request outstanding", out_data_o));
        end else begin
          want = predicted_rsp_q.pop_front();
          if (out_data_o.heater_drive !== want.heater_drive)
            report_mismatch($sformatf("heater_drive got %b want %b",
                                      out_data_o.heater_drive, want.heater_drive));
          if (out_data_o.cooler_drive !== want.cooler_drive)
            report_mismatch($sformatf("cooler_drive got %b want %b",
                                      out_data_o.cooler_drive, want.cooler_drive));
          if (out_data_o.heater_alarm !== want.heater_alarm)
            report_mismatch($sformatf("heater_alarm got %b want %b",
                                      out_data_o.heater_alarm, want.heater_alarm));
          if (out_data_o.cooler_alarm !== want.cooler_alarm)
            report_mismatch($sformatf("cooler_alarm got %b want %b",
                                      out_data_o.cooler_alarm, want.cooler_alarm));
          if (out_data_o.band !== want.band)
            report_mismatch($sformatf("band got %0d want %0d", out_data_o.band, want.band));
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (pending_ops.size() <= TAIL_OPS || $urandom_range(0, 7) != 0) begin
        out_ready_i <= 1'b1;
      end else begin
        stall_left = $urandom_range(0, 13);
        out_ready_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               predicted_rsp_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    // Directed requests under the reset limits: 40, 20 and a half band of 10.
    push_tick(1'b0, 0);
    push_tick(1'b0, TEMP_MAX);
    push_tick(1'b0, 2000);
    push_tick(1'b0, 2001);
    push_tick(1'b0, 2999);
    push_tick(1'b0, 3000);
    push_tick(1'b0, 3999);
    push_tick(1'b0, 4000);
    push_tick(1'b0, 1999);
    push_tick(1'b0, 4001);
    push_tick(1'b1, TEMP_MAX);
    push_tick(1'b0, 16'h5555);
    push_tick(1'b0, 16'hAAAA);
    push_tick(1'b1, 0);
    push_tick(1'b0, 3500);
    // Fault targets only grow from here on, so the counter never overtakes them
    // until the final phases, which exercise saturation and a passed target.
    random_phase(60, 21, 3, 45, 60);
    random_phase(30, 30, 3, 45, 60);
    random_phase(10, 50, 4, 45, 60);
    random_phase(0, 0, 4, 45, 60);
    random_phase(127, 0, 5, 45, 60);
    random_phase(99, 99, 10, 45, 70);
    random_phase(127, 127, 99, 150, 90);
    random_phase(10, 50, 0, 350, 95);
    random_phase(127, 0, 127, 500, 95);
    random_phase(40, 20, 5, 40, 80);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_ops.size() != 0 || in_valid_i || predicted_rsp_q.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Checked %0d requests across %0d register writes in %0d cycles.",
             req_count, write_count, cycle_count);
    $display("Heater faults %0d, cooler faults %0d, ticks at counter saturation %0d.",
             heater_trips, cooler_trips, sat_ticks);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tfw_pkg.sv
hw/rtl/tfw_front.sv
hw/rtl/tfw_queue.sv
hw/rtl/tfw_back.sv
hw/rtl/thermostat_with_fault_watch.sv
tb/tb.sv
